### design/fpfa_pkg.sv
package fpfa_pkg;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_ALLOC = 2'd2;

	localparam logic [1:0] POL_FIRST = 2'd0;
	localparam logic [1:0] POL_BEST  = 2'd1;
	localparam logic [1:0] POL_WORST = 2'd2;

	localparam logic REG_FIT_POLICY    = 1'b0;
	localparam logic REG_BLOCKS_IN_USE = 1'b1;

	localparam logic [1:0] FIT_POLICY_RESET    = POL_FIRST;
	localparam logic [4:0] BLOCKS_IN_USE_RESET = 5'd16;

	typedef struct packed {
		logic [1:0]  op;
		logic [3:0]  load_index;
		logic [15:0] load_size;
		logic [15:0] request_size;
	} cmd_t;

	typedef struct packed {
		logic       granted;
		logic [3:0] granted_block;
	} result_t;

endpackage

### design/fixed_partition_fit_allocator_core.sv
// Fixed-partition fit allocator.
// Command channel: an item on cmd is taken at a rising edge with start high
// and busy low. A load item writes one block size and a clear item drops all
// taken marks; both finish at the accepting edge and busy stays low.
// An allocate item scans blocks 0 .. n-1 (n = blocks_in_use, clamped to
// MAX_BLOCKS) through one size-table read port and one shared comparator,
// one block per cycle. done follows the scan and a final compare step, and
// holds for one cycle with result; the next item can be taken once the block
// is back in idle with busy low. With n zero the scan is skipped: done is high in
// the cycle right after the accepting edge.
// The winner's taken mark is set at the edge that ends the done cycle.
// The receiver cannot stall: result is valid only while done is high.
// Configuration: APB port, fit_policy at 0x0, blocks_in_use at 0x4; the user
// writes them only while busy is low, not enforced by the block; pready is tied high.
// Reset (arst_n low) clears all taken marks, fit_policy to first fit and
// blocks_in_use to 16. Block sizes are undefined until loaded.
module fixed_partition_fit_allocator_core #(
	parameter int MAX_BLOCKS = 16,
	parameter int SIZE_BITS  = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  fpfa_pkg::cmd_t       cmd,
	output logic                 done,
	output fpfa_pkg::result_t    result,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
	localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_LAST = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0]           state_q;
	logic [1:0]           fit_policy_q;
	logic [4:0]           blocks_in_use_q;
	logic [MAX_BLOCKS-1:0] taken_q;
	logic [SIZE_BITS-1:0] mem [MAX_BLOCKS];
	logic [SIZE_BITS-1:0] rdata_q;
	logic [SIZE_BITS-1:0] req_q;
	logic [SIZE_BITS-1:0] best_q;
	logic [IDX_W-1:0]     cnt_q;
	logic [IDX_W-1:0]     ridx_q;
	logic [IDX_W-1:0]     pick_q;
	logic [CNT_W-1:0]     n_q;
	logic                 rvalid_q;
	logic                 found_q;

	logic                 accept;
	logic                 cfg_wr;
	logic                 load_ok;
	logic [CNT_W-1:0]     n_clamped;
	logic                 fits;
	logic                 take;
	logic                 last_read;

	assign accept  = start && !busy;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign pready  = 1'b1;
	assign busy    = (state_q != S_IDLE);
	assign done    = (state_q == S_DONE);
	assign load_ok = CMP_W'(cmd.load_index) < CMP_W'(MAX_BLOCKS);

	assign n_clamped = (CMP_W'(blocks_in_use_q) > CMP_W'(MAX_BLOCKS)) ?
		CNT_W'(MAX_BLOCKS) : CNT_W'(blocks_in_use_q);

	assign last_read = (CNT_W'(cnt_q) + CNT_W'(1)) == n_q;

	always_comb begin
		fits = rvalid_q && !taken_q[ridx_q] && (rdata_q >= req_q);
		take = fits && (!found_q ||
			(fit_policy_q == fpfa_pkg::POL_BEST && rdata_q < best_q) ||
			(fit_policy_q == fpfa_pkg::POL_WORST && rdata_q > best_q));
	end

	always_comb begin
		result.granted       = found_q;
		result.granted_block = found_q ? 4'(pick_q) : 4'd0;
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			fpfa_pkg::REG_FIT_POLICY:    prdata[1:0] = fit_policy_q;
			fpfa_pkg::REG_BLOCKS_IN_USE: prdata[4:0] = blocks_in_use_q;
			default:                     prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_policy_q    <= fpfa_pkg::FIT_POLICY_RESET;
			blocks_in_use_q <= fpfa_pkg::BLOCKS_IN_USE_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				fpfa_pkg::REG_FIT_POLICY:    fit_policy_q <= pwdata[1:0];
				fpfa_pkg::REG_BLOCKS_IN_USE: blocks_in_use_q <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && cmd.op == fpfa_pkg::OP_LOAD && load_ok) begin
			mem[IDX_W'(cmd.load_index)] <= SIZE_BITS'(cmd.load_size);
		end
		rdata_q <= mem[cnt_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			taken_q  <= '0;
			rvalid_q <= 1'b0;
			found_q  <= 1'b0;
			cnt_q    <= '0;
			n_q      <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					rvalid_q <= 1'b0;
					if (accept) begin
						unique case (cmd.op)
							fpfa_pkg::OP_CLEAR: taken_q <= '0;
							fpfa_pkg::OP_ALLOC: begin
								found_q <= 1'b0;
								cnt_q   <= '0;
								n_q     <= n_clamped;
								state_q <= (n_clamped == '0) ? S_DONE : S_SCAN;
							end
							default: ;
						endcase
					end
				end
				S_SCAN: begin
					rvalid_q <= 1'b1;
					if (take) begin
						found_q <= 1'b1;
					end
					if (last_read) begin
						state_q <= S_LAST;
					end else begin
						cnt_q <= cnt_q + IDX_W'(1);
					end
				end
				S_LAST: begin
					rvalid_q <= 1'b0;
					if (take) begin
						found_q <= 1'b1;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (found_q) begin
						taken_q[pick_q] <= 1'b1;
					end
					cnt_q   <= '0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		ridx_q <= cnt_q;
		if (accept) begin
			req_q <= SIZE_BITS'(cmd.request_size);
		end
		if (take) begin
			pick_q <= ridx_q;
			best_q <= rdata_q;
		end
	end

`ifndef SYNTHESIS
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("done outside busy");

	a_grant_marks: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.granted |=> taken_q[$past(pick_q)])
		else $error("granted block not marked taken");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.granted |-> result.granted_block == 4'd0)
		else $error("failed result with nonzero block");

	a_alloc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd.op == fpfa_pkg::OP_ALLOC |=> busy)
		else $error("allocate item did not raise busy");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> CNT_W'(cnt_q) < n_q)
		else $error("scan index beyond block count");
`endif

endmodule
